FILE: rtl/assert_macros.svh
// assertion helpers for the rgbe scanline run-length decoder
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property checked on every rising edge outside reset
`define RSRLE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define RSRLE_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/rsrle_pkg.sv
// shared types and constants of the rgbe scanline run-length decoder
// no dependencies; imported by every module of the block
`default_nettype none

package rsrle_pkg;

    // decoding phase of the current scanline
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_OLD,
        PH_CODE,
        PH_RUN,
        PH_LIT
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_LENGTH,
        ERR_OVERRUN,
        ERR_MARKERS
    } err_t;

    // one run descriptor as it travels from the decoder to the output stage
    typedef struct packed {
        logic        all_components;
        logic [1:0]  plane;
        logic [11:0] first_pixel;
        logic [12:0] pixel_count;
        logic [7:0]  comp_red;
        logic [7:0]  comp_green;
        logic [7:0]  comp_blue;
        logic [7:0]  comp_exponent;
        logic        line_done;
        err_t        error_code;
    } desc_t;

    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);

    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 5;

endpackage

`default_nettype wire

FILE: rtl/rsrle_front.sv
// byte decoder: classifies each encoded byte and builds run descriptors
// depends on rsrle_pkg (phase_t, err_t, desc_t)
`default_nettype none

module rsrle_front
    import rsrle_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [12:0] line_width,
    input  logic        accept,
    input  logic [7:0]  in_byte,
    input  logic        resync,
    output logic        push,
    output desc_t       desc
);

    localparam int PW = $clog2(MAX_WIDTH + 1);
    localparam int SW = PW + 8;
    localparam logic [15:0] MAX_W16 = 16'(MAX_WIDTH);
    localparam int RST_W = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;

    phase_t        phase_reg, phase_next;
    logic [1:0]    slot_reg, slot_next;
    logic [23:0]   held_reg, held_next;
    logic [1:0]    plane_reg, plane_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]    pend_reg, pend_next;
    logic [2:0]    rs_reg, rs_next;
    logic [31:0]   prev_reg, prev_next;
    logic          err_reg, err_next;
    logic [PW-1:0] width_reg, width_next;

    // state as seen after an optional resync
    phase_t        ph_e;
    logic [1:0]    slot_e;
    logic [23:0]   held_e;
    logic [1:0]    plane_e;
    logic [PW-1:0] pos_e;
    logic [7:0]    pend_e;
    logic [2:0]    rs_e;
    logic          err_e;
    logic [PW-1:0] width_e;
    logic [15:0]   sampled16;

    logic [7:0]    r_b, g_b, b_b;
    logic          grp_done;
    logic          new_hdr;
    logic          len_ok;
    logic          marker;
    logic [31:0]   mk_count;
    logic [PW-1:0] remaining;
    logic [PW-1:0] old_count;
    logic [PW-1:0] old_pos;
    logic          old_done;
    logic [31:0]   old_pixel;
    logic [7:0]    code_len;
    logic          code_over;
    logic [7:0]    sp_raw;
    logic [SW-1:0] sp_sum;
    logic          sp_clip;
    logic [7:0]    sp_len;
    logic [PW-1:0] sp_end;
    logic          sp_full;
    logic [7:0]    pend_dec;

    // shared decode of the current beat
    always_comb
    begin
        ph_e    = resync ? PH_HEADER : phase_reg;
        slot_e  = resync ? 2'd0 : slot_reg;
        held_e  = resync ? 24'd0 : held_reg;
        plane_e = resync ? 2'd0 : plane_reg;
        pos_e   = resync ? '0 : pos_reg;
        pend_e  = resync ? 8'd0 : pend_reg;
        rs_e    = resync ? 3'd0 : rs_reg;
        err_e   = resync ? 1'b0 : err_reg;

        // width is sampled at the first byte of each scanline
        if (line_width == 13'd0)
            sampled16 = 16'd1;
        else if (16'(line_width) > MAX_W16)
            sampled16 = MAX_W16;
        else
            sampled16 = 16'(line_width);
        width_e = (ph_e == PH_HEADER && slot_e == 2'd0) ? PW'(sampled16) : width_reg;

        r_b = held_e[7:0];
        g_b = held_e[15:8];
        b_b = held_e[23:16];
        grp_done = (slot_e == 2'd3);
        new_hdr = (width_e >= PW'(8)) && (r_b == 8'd2) && (g_b == 8'd2) && !b_b[7];
        len_ok = ({1'b0, b_b[6:0], in_byte} == 16'(width_e));

        marker = (r_b == 8'd1) && (g_b == 8'd1) && (b_b == 8'd1);
        mk_count = 32'(in_byte) << {rs_e[1:0], 3'b000};
        remaining = width_e - pos_e;
        if (!marker)
            old_count = PW'(1);
        else if (mk_count > 32'(remaining))
            old_count = remaining;
        else
            old_count = PW'(mk_count);
        old_pos = pos_e + old_count;
        old_done = (old_pos >= width_e);
        old_pixel = {in_byte, b_b, g_b, r_b};

        // code byte above 128 is a run, otherwise a literal count
        code_len = (in_byte > 8'd128) ? {1'b0, in_byte[6:0]} : in_byte;
        code_over = (SW'(pos_e) + SW'(code_len)) > SW'(width_e);

        sp_raw = (ph_e == PH_RUN) ? pend_e : 8'd1;
        if (sp_raw == 8'd0)
            sp_raw = 8'd1;
        sp_sum = SW'(pos_e) + SW'(sp_raw);
        sp_clip = sp_sum > SW'(width_e);
        sp_len = sp_clip ? 8'(width_e - pos_e) : sp_raw;
        sp_end = sp_clip ? width_e : PW'(sp_sum);
        sp_full = (sp_end >= width_e);
        pend_dec = (pend_e != 8'd0) ? pend_e - 8'd1 : 8'd0;
    end

    // next state
    always_comb
    begin
        logic restart;
        restart = 1'b0;
        phase_next = phase_reg;
        slot_next  = slot_reg;
        held_next  = held_reg;
        plane_next = plane_reg;
        pos_next   = pos_reg;
        pend_next  = pend_reg;
        rs_next    = rs_reg;
        prev_next  = prev_reg;
        err_next   = err_reg;
        width_next = width_reg;
        if (accept)
        begin
            phase_next = ph_e;
            slot_next  = slot_e;
            held_next  = held_e;
            plane_next = plane_e;
            pos_next   = pos_e;
            pend_next  = pend_e;
            rs_next    = rs_e;
            err_next   = err_e;
            if (!err_e)
            begin
                width_next = width_e;
                unique case (ph_e) inside
                    PH_HEADER, PH_OLD:
                    begin
                        if (!grp_done)
                        begin
                            if (slot_e == 2'd0)
                                held_next = {16'd0, in_byte};
                            else
                                held_next = held_e | (24'(in_byte) << {slot_e, 3'b000});
                            slot_next = slot_e + 2'd1;
                        end
                        else
                        begin
                            slot_next = 2'd0;
                            if (ph_e == PH_HEADER)
                                phase_next = PH_OLD;
                            if (ph_e == PH_HEADER && new_hdr)
                            begin
                                if (!len_ok)
                                    err_next = 1'b1;
                                else
                                    phase_next = PH_CODE;
                            end
                            else if (marker)
                            begin
                                if (rs_e[2])
                                    err_next = 1'b1;
                                else
                                begin
                                    rs_next = rs_e + 3'd1;
                                    if (in_byte != 8'd0)
                                    begin
                                        pos_next = old_pos;
                                        restart = old_done;
                                    end
                                end
                            end
                            else
                            begin
                                prev_next = old_pixel;
                                rs_next = 3'd0;
                                pos_next = old_pos;
                                restart = old_done;
                            end
                        end
                    end
                    PH_CODE:
                    begin
                        if (code_len != 8'd0)
                        begin
                            if (code_over)
                                err_next = 1'b1;
                            else
                            begin
                                pend_next = code_len;
                                phase_next = (in_byte > 8'd128) ? PH_RUN : PH_LIT;
                            end
                        end
                    end
                    PH_RUN, PH_LIT:
                    begin
                        if (ph_e == PH_RUN)
                        begin
                            pend_next = 8'd0;
                            phase_next = PH_CODE;
                        end
                        else
                        begin
                            pend_next = pend_dec;
                            if (pend_dec == 8'd0)
                                phase_next = PH_CODE;
                        end
                        pos_next = sp_end;
                        if (sp_full)
                        begin
                            prev_next[{plane_e, 3'b000} +: 8] = in_byte;
                            if (plane_e == 2'd3)
                                restart = 1'b1;
                            else
                            begin
                                plane_next = plane_e + 2'd1;
                                pos_next = '0;
                                phase_next = PH_CODE;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (restart)
                begin
                    phase_next = PH_HEADER;
                    slot_next  = 2'd0;
                    held_next  = 24'd0;
                    plane_next = 2'd0;
                    pos_next   = '0;
                    pend_next  = 8'd0;
                    rs_next    = 3'd0;
                end
            end
        end
    end

    // descriptor for the current beat
    always_comb
    begin
        push = 1'b0;
        desc = '0;
        desc.plane = plane_e;
        desc.first_pixel = 12'(pos_e);
        if (accept && !err_e)
        begin
            unique case (ph_e) inside
                PH_HEADER, PH_OLD:
                begin
                    if (grp_done)
                    begin
                        if (ph_e == PH_HEADER && new_hdr)
                        begin
                            if (!len_ok)
                            begin
                                push = 1'b1;
                                desc.line_done = 1'b1;
                                desc.error_code = ERR_LENGTH;
                            end
                        end
                        else if (marker && rs_e[2])
                        begin
                            push = 1'b1;
                            desc.line_done = 1'b1;
                            desc.error_code = ERR_MARKERS;
                        end
                        else if (!marker || in_byte != 8'd0)
                        begin
                            push = 1'b1;
                            desc.all_components = 1'b1;
                            desc.plane = 2'd0;
                            desc.pixel_count = 13'(old_count);
                            desc.comp_red      = marker ? prev_reg[7:0]   : old_pixel[7:0];
                            desc.comp_green    = marker ? prev_reg[15:8]  : old_pixel[15:8];
                            desc.comp_blue     = marker ? prev_reg[23:16] : old_pixel[23:16];
                            desc.comp_exponent = marker ? prev_reg[31:24] : old_pixel[31:24];
                            desc.line_done = old_done;
                        end
                    end
                end
                PH_CODE:
                begin
                    if (code_len != 8'd0 && code_over)
                    begin
                        push = 1'b1;
                        desc.line_done = 1'b1;
                        desc.error_code = ERR_OVERRUN;
                    end
                end
                PH_RUN, PH_LIT:
                begin
                    push = 1'b1;
                    desc.pixel_count = 13'(sp_len);
                    desc.comp_red = in_byte;
                    desc.line_done = sp_full && (plane_e == 2'd3);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            slot_reg  <= 2'd0;
            held_reg  <= 24'd0;
            plane_reg <= 2'd0;
            pos_reg   <= '0;
            pend_reg  <= 8'd0;
            rs_reg    <= 3'd0;
            prev_reg  <= 32'd0;
            err_reg   <= 1'b0;
            width_reg <= PW'(RST_W);
        end
        else
        begin
            phase_reg <= phase_next;
            slot_reg  <= slot_next;
            held_reg  <= held_next;
            plane_reg <= plane_next;
            pos_reg   <= pos_next;
            pend_reg  <= pend_next;
            rs_reg    <= rs_next;
            prev_reg  <= prev_next;
            err_reg   <= err_next;
            width_reg <= width_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rsrle_queue.sv
// short descriptor queue between the byte decoder and the output stage
// depends on rsrle_pkg (desc_t, QDEPTH, QAW)
`default_nettype none

module rsrle_queue
    import rsrle_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    output logic  not_full,
    output logic  head_valid,
    output desc_t head,
    input  logic  pop
);

    desc_t          entry_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;

    assign not_full   = (count_reg != (QAW + 1)'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + (QAW + 1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QAW + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

`default_nettype wire

FILE: rtl/rsrle_back.sv
// output stage: holds one descriptor and packs it onto the master stream
// depends on rsrle_pkg (desc_t, M_TDATA_W, M_TUSER_W)
`default_nettype none

module rsrle_back
    import rsrle_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  desc_t                head,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // first_pixel, pixel_count, comp_red, comp_green, comp_blue, comp_exponent, zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    // all_components, plane, error_code
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast
);

    desc_t out_reg;
    logic  valid_reg, valid_next;

    assign pop = head_valid && (!valid_reg || m_tready);

    always_comb
    begin
        if (pop)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_reg <= head;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, out_reg.comp_exponent, out_reg.comp_blue, out_reg.comp_green,
                       out_reg.comp_red, out_reg.pixel_count, out_reg.first_pixel};
    assign m_tuser  = {out_reg.error_code, out_reg.plane, out_reg.all_components};
    assign m_tlast  = out_reg.line_done;

endmodule

`default_nettype wire

FILE: rtl/rgbe_scanline_rle_decoder.sv
// Scanline run-length decoder for shared-exponent (RGBE) pixel streams.
// Slave stream: one encoded byte per beat in s_tdata, s_tuser set on the
// first byte of a new scanline to drop the current one and clear an error.
// Master stream: one run descriptor per beat ("pixels first_pixel onward,
// pixel_count of them, get these values"), tlast on the descriptor that ends
// or aborts a line, error code in tuser. Bytes that only fill a pixel group,
// a header or a code produce no descriptor.
// Config channel: cfg_data is the line width, taken at the next line start.
// Throughput is one byte per cycle while the queue has room; the decoder does
// all per-byte work in the cycle the byte is taken. A descriptor is written
// into the four-entry queue at the edge that takes its byte, and the output
// register picks it up from the queue head once it is free.
// When the receiver stalls, the queue fills and s_tready drops once it is
// full; the decoder keeps taking bytes until then, including bytes that
// would not produce a descriptor.
// Reset clears all line state, the last pixel to zero and the width to 4096;
// no clearing pass is needed.
// depends on rsrle_pkg, rsrle_front, rsrle_queue, rsrle_back, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rgbe_scanline_rle_decoder
    import rsrle_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [12:0]          cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // in_byte
    input  logic [7:0]           s_tdata,
    // resync
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // first_pixel, pixel_count, comp_red, comp_green, comp_blue, comp_exponent, zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    // all_components, plane, error_code
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast
);

    logic [12:0] line_width_reg;
    logic        accept;
    logic        push;
    desc_t       push_desc;
    logic        q_not_full;
    logic        q_valid;
    desc_t       q_head;
    logic        q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_width_reg <= 13'd4096;
        else if (cfg_valid)
            line_width_reg <= cfg_data;
    end

    assign s_tready = q_not_full;
    assign accept   = s_tvalid && s_tready;

    rsrle_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_width (line_width_reg),
        .accept     (accept),
        .in_byte    (s_tdata),
        .resync     (s_tuser[0]),
        .push       (push),
        .desc       (push_desc)
    );

    rsrle_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .not_full   (q_not_full),
        .head_valid (q_valid),
        .head       (q_head),
        .pop        (q_pop)
    );

    rsrle_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head       (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // error beats carry no pixels and always close the line
    `RSRLE_ASSERT(a_err_shape, clk, rst_n, (m_tvalid && m_tuser[4:3] != ERR_NONE) |-> (m_tdata[24:12] == 13'd0 && m_tlast), "error descriptor with pixels or without tlast")
    // a clean descriptor always writes at least one pixel
    `RSRLE_NEVER(a_ok_count, clk, rst_n, m_tvalid && m_tuser[4:3] == ERR_NONE && m_tdata[24:12] == 13'd0, "empty descriptor without error")
    // the queue only fills up while the receiver holds off
    `RSRLE_ASSERT(a_fill_stall, clk, rst_n, $fell(s_tready) |-> $past(m_tvalid && !m_tready), "input stalled without output backpressure")

endmodule

`default_nettype wire
